FILE: sv/tdt_pkg.sv
`timescale 1ns / 1ps
// Shared widths, stage counts and classification codes for the deformation tensor.
package tdt_pkg;
  localparam int DIFF_W    = 33;  // difference of two 32-bit words
  localparam int PROD_W    = 66;  // product of two differences
  localparam int CROSS_W   = 67;  // difference of two products
  localparam int MAG_W     = 66;  // magnitude of a cross term
  localparam int QB        = 33;  // quotient bits developed before the saturation check
  localparam int FRONT_ST  = 3;   // differences, products, cross terms
  localparam int DIV_ST    = QB + 2;  // set-up, one stage per quotient bit, round
  localparam int CLASS_ST  = 2;
  localparam int NST       = FRONT_ST + DIV_ST + CLASS_ST;

  typedef enum logic [1:0] {
    KIND_DIVERGENT  = 2'd0,
    KIND_CONVERGENT = 2'd1,
    KIND_STRETCHING = 2'd2
  } kind_t;
endpackage

FILE: sv/triangle_deformation_tensor.sv
`timescale 1ns / 1ps
// Top level: triangle affine Jacobian pipeline with valid/ready channels.
//
//   channel | handshake            | words
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_ready  | x0 y0 x1 y1 x2 y2 u0 v0 u1 v1 u2 v2
//   out     | out_valid/ out_ready | jac_a jac_b jac_d jac_e offset_c offset_f
//           |                      | degenerate kind
//
// One triangle per cycle unless the output stalls: three front stages, one
// divider set-up stage, one stage per quotient bit (33), one rounding stage,
// two classification stages. The four divisions run side by side.
// Reset clears the stage valid bits only. Each stage holds its word while the
// stage after it is full and stalled, so bubbles close up under a stall.
module triangle_deformation_tensor import tdt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] x0, y0, x1, y1, x2, y2,
  input  logic signed [31:0] u0, v0, u1, v1, u2, v2,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] jac_a, jac_b, jac_d, jac_e,
  output logic signed [31:0] offset_c,
  output logic signed [31:0] offset_f,
  output logic               degenerate,
  output logic [1:0]         kind
);
  localparam int DIV0 = FRONT_ST;
  localparam int CLS0 = FRONT_ST + DIV_ST;

  logic [NST-1:0] valid;
  logic [NST:0]   take;
  logic [NST-1:0] en;

  always_comb begin
    take[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      take[k] = !valid[k] || take[k+1];
    end
  end
  assign en        = take[NST-1:0];
  assign in_ready  = take[0];
  assign out_valid = valid[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (take[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (take[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  logic signed [CROSS_W-1:0] det, num_a, num_b, num_d, num_e;
  logic signed [31:0]        oc_f, of_f;
  logic signed [31:0]        qa, qb, qd, qe;

  tdt_front u_front (
    .clk, .en(en[FRONT_ST-1:0]),
    .x0, .y0, .x1, .y1, .x2, .y2, .u0, .v0, .u1, .v1, .u2, .v2,
    .det, .num_a, .num_b, .num_d, .num_e,
    .offset_c(oc_f), .offset_f(of_f)
  );

  tdt_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
    .clk, .en(en[CLS0-1:DIV0]), .num(num_a), .den(det), .quo(qa));
  tdt_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
    .clk, .en(en[CLS0-1:DIV0]), .num(num_b), .den(det), .quo(qb));
  tdt_div #(.FRAC_BITS(FRAC_BITS)) u_div_d (
    .clk, .en(en[CLS0-1:DIV0]), .num(num_d), .den(det), .quo(qd));
  tdt_div #(.FRAC_BITS(FRAC_BITS)) u_div_e (
    .clk, .en(en[CLS0-1:DIV0]), .num(num_e), .den(det), .quo(qe));

  tdt_class u_class (
    .clk, .en(en[NST-1:CLS0]),
    .ja(qa), .jb(qb), .jd(qd), .je(qe),
    .jac_a, .jac_b, .jac_d, .jac_e, .kind
  );

  // offsets and degenerate flag travel alongside the divider words
  logic signed [31:0] oc_d [DIV0:NST-1];
  logic signed [31:0] of_d [DIV0:NST-1];
  logic               dg_d [DIV0:NST-1];

  for (genvar k = DIV0; k < NST; k++) begin : g_side
    if (k == DIV0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[k]) begin
          oc_d[k] <= oc_f;
          of_d[k] <= of_f;
          dg_d[k] <= (det == '0);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[k]) begin
          oc_d[k] <= oc_d[k-1];
          of_d[k] <= of_d[k-1];
          dg_d[k] <= dg_d[k-1];
        end
      end
    end
  end

  assign offset_c   = oc_d[NST-1];
  assign offset_f   = of_d[NST-1];
  assign degenerate = dg_d[NST-1];

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> jac_a == 0 && jac_b == 0 && jac_d == 0 && jac_e == 0
      && kind == KIND_STRETCHING)
    else $error("degenerate word with nonzero Jacobian");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind != 2'd3)
    else $error("unused kind code");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_flow_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");
endmodule

FILE: sv/tdt_front.sv
`timescale 1ns / 1ps
// Front stages: edge differences, cross products and the signed cross terms.
module tdt_front import tdt_pkg::*; (
  input  logic                      clk,
  input  logic [FRONT_ST-1:0]       en,
  input  logic signed [31:0]        x0, y0, x1, y1, x2, y2,
  input  logic signed [31:0]        u0, v0, u1, v1, u2, v2,
  output logic signed [CROSS_W-1:0] det,
  output logic signed [CROSS_W-1:0] num_a, num_b, num_d, num_e,
  output logic signed [31:0]        offset_c,
  output logic signed [31:0]        offset_f
);
  logic signed [DIFF_W-1:0] m00, m01, m10, m11, bu0, bu1, bv0, bv1;
  logic signed [PROD_W-1:0] pm1, pm2, pa1, pa2, pb1, pb2, pd1, pd2, pe1, pe2;
  logic signed [31:0]       oc0, of0, oc1, of1;
  logic signed [DIFF_W-1:0] c_full, f_full;

  function automatic logic signed [31:0] sat32(input logic signed [DIFF_W-1:0] v);
    if (v[DIFF_W-1] != v[DIFF_W-2]) begin
      sat32 = v[DIFF_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  assign c_full = DIFF_W'(u0) - DIFF_W'(x0);
  assign f_full = DIFF_W'(v0) - DIFF_W'(y0);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m00 <= DIFF_W'(x1) - DIFF_W'(x0);
      m01 <= DIFF_W'(y1) - DIFF_W'(y0);
      m10 <= DIFF_W'(x2) - DIFF_W'(x0);
      m11 <= DIFF_W'(y2) - DIFF_W'(y0);
      bu0 <= DIFF_W'(u1) - DIFF_W'(u0);
      bu1 <= DIFF_W'(u2) - DIFF_W'(u0);
      bv0 <= DIFF_W'(v1) - DIFF_W'(v0);
      bv1 <= DIFF_W'(v2) - DIFF_W'(v0);
      oc0 <= sat32(c_full);
      of0 <= sat32(f_full);
    end
    if (en[1]) begin
      pm1 <= PROD_W'(m00) * PROD_W'(m11);
      pm2 <= PROD_W'(m01) * PROD_W'(m10);
      pa1 <= PROD_W'(m11) * PROD_W'(bu0);
      pa2 <= PROD_W'(m01) * PROD_W'(bu1);
      pb1 <= PROD_W'(m00) * PROD_W'(bu1);
      pb2 <= PROD_W'(m10) * PROD_W'(bu0);
      pd1 <= PROD_W'(m11) * PROD_W'(bv0);
      pd2 <= PROD_W'(m01) * PROD_W'(bv1);
      pe1 <= PROD_W'(m00) * PROD_W'(bv1);
      pe2 <= PROD_W'(m10) * PROD_W'(bv0);
      oc1 <= oc0;
      of1 <= of0;
    end
    if (en[2]) begin
      det      <= CROSS_W'(pm1) - CROSS_W'(pm2);
      num_a    <= CROSS_W'(pa1) - CROSS_W'(pa2);
      num_b    <= CROSS_W'(pb1) - CROSS_W'(pb2);
      num_d    <= CROSS_W'(pd1) - CROSS_W'(pd2);
      num_e    <= CROSS_W'(pe1) - CROSS_W'(pe2);
      offset_c <= oc1;
      offset_f <= of1;
    end
  end
endmodule

FILE: sv/tdt_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: round(num * 2^FRAC_BITS / den), saturated to 32 bits.
module tdt_div import tdt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic [DIV_ST-1:0]         en,
  input  logic signed [CROSS_W-1:0] num,
  input  logic signed [CROSS_W-1:0] den,
  output logic signed [31:0]        quo
);
  localparam int NUM_W = MAG_W + FRAC_BITS;
  localparam int CMP_W = MAG_W + QB;

  logic [MAG_W-1:0] n_mag, d_mag;
  logic [NUM_W-1:0] n_sh;
  logic [CROSS_W-1:0] n_abs, d_abs;

  // per-stage words of the divider pipe
  logic [MAG_W-1:0] r   [QB+1];
  logic [MAG_W-1:0] d   [QB+1];
  logic [QB-1:0]    q   [QB+1];
  logic [QB-1:0]    nlo [QB+1];
  logic             neg [QB+1];
  logic             ovf [QB+1];
  logic             zro [QB+1];

  assign n_abs = num[CROSS_W-1] ? CROSS_W'(-num) : num;
  assign d_abs = den[CROSS_W-1] ? CROSS_W'(-den) : den;
  assign n_mag = n_abs[MAG_W-1:0];
  assign d_mag = d_abs[MAG_W-1:0];
  assign n_sh  = {n_mag, FRAC_BITS'(0)};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r[0]   <= MAG_W'(n_sh >> QB);
      d[0]   <= d_mag;
      q[0]   <= '0;
      nlo[0] <= n_sh[QB-1:0];
      neg[0] <= num[CROSS_W-1] ^ den[CROSS_W-1];
      ovf[0] <= CMP_W'(n_sh) >= {d_mag, QB'(0)};
      zro[0] <= (den == '0);
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [MAG_W:0] t;
    assign t = {r[s-1], nlo[s-1][QB-1]};
    always_ff @(posedge clk) begin
      if (en[s]) begin
        if (t >= {1'b0, d[s-1]}) begin
          r[s] <= MAG_W'(t - {1'b0, d[s-1]});
          q[s] <= {q[s-1][QB-2:0], 1'b1};
        end else begin
          r[s] <= t[MAG_W-1:0];
          q[s] <= {q[s-1][QB-2:0], 1'b0};
        end
        nlo[s] <= {nlo[s-1][QB-2:0], 1'b0};
        d[s]   <= d[s-1];
        neg[s] <= neg[s-1];
        ovf[s] <= ovf[s-1];
        zro[s] <= zro[s-1];
      end
    end
  end

  logic [QB:0]   qr;
  logic [QB:0]   limit;
  logic [QB:0]   qs;
  logic          rnd;

  assign rnd   = {r[QB], 1'b0} >= {1'b0, d[QB]};
  assign qr    = {1'b0, q[QB]} + (QB+1)'(rnd);
  assign limit = neg[QB] ? (QB+1)'(33'h0_8000_0000) : (QB+1)'(33'h0_7fff_ffff);
  assign qs    = (ovf[QB] || qr > limit) ? limit : qr;

  always_ff @(posedge clk) begin
    if (en[QB+1]) begin
      if (zro[QB]) begin
        quo <= '0;
      end else if (neg[QB]) begin
        quo <= 32'(-qs);
      end else begin
        quo <= qs[31:0];
      end
    end
  end
endmodule

FILE: sv/tdt_class.sv
`timescale 1ns / 1ps
// Classification stages: determinant and trace signs of the finished Jacobian.
module tdt_class import tdt_pkg::*; (
  input  logic                clk,
  input  logic [CLASS_ST-1:0] en,
  input  logic signed [31:0]  ja, jb, jd, je,
  output logic signed [31:0]  jac_a, jac_b, jac_d, jac_e,
  output logic [1:0]          kind
);
  logic signed [63:0] ae, bd;
  logic signed [32:0] tr;
  logic signed [31:0] a1, b1, d1, e1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ae <= 64'(ja) * 64'(je);
      bd <= 64'(jb) * 64'(jd);
      tr <= 33'(ja) + 33'(je);
      a1 <= ja;
      b1 <= jb;
      d1 <= jd;
      e1 <= je;
    end
    if (en[1]) begin
      jac_a <= a1;
      jac_b <= b1;
      jac_d <= d1;
      jac_e <= e1;
      if (ae > bd && tr > 0) begin
        kind <= KIND_DIVERGENT;
      end else if (ae > bd && tr < 0) begin
        kind <= KIND_CONVERGENT;
      end else begin
        kind <= KIND_STRETCHING;
      end
    end
  end
endmodule

FILE: tb/tb_triangle_deformation_tensor.sv
`timescale 1ns / 1ps
// Self-checking bench for the triangle Jacobian pipeline: random and corner triangles.
module tb_triangle_deformation_tensor;
  import tdt_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int N_RANDOM = 1200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [31:0] a, b, d, e, c, f;
    logic degen;
    kind_t kind;
  } jac_t;

  class jacobian_scoreboard;
    jac_t pending[$];
    int errors;

    // round(num * 2^FRAC_BITS / den) with halves away from zero, then clamp
    function automatic logic signed [31:0] qdiv(logic signed [66:0] num,
                                                 logic signed [66:0] den);
      logic [130:0] n, dm, q, r;
      logic neg;
      neg = num[66] != den[66];
      n = num[66] ? -num : num;
      dm = den[66] ? -den : den;
      n = n << FRAC_BITS;
      q = n / dm;
      r = n % dm;
      if ((r << 1) >= dm) q = q + 1;
      if (neg) begin
        if (q > 131'h80000000) q = 131'h80000000;
        return -q[31:0];
      end
      if (q > 131'h7fffffff) q = 131'h7fffffff;
      return q[31:0];
    endfunction

    function automatic logic signed [31:0] clamp(logic signed [32:0] v);
      if (v > 33'sd2147483647) return 32'sh7fffffff;
      if (v < -33'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_triangle(logic signed [31:0] vx0, vy0, vx1, vy1, vx2, vy2,
                                logic signed [31:0] vu0, vv0, vu1, vv1, vu2, vv2);
      logic signed [66:0] m00, m01, m10, m11, bu0, bu1, bv0, bv1, det;
      logic signed [63:0] ae, bd, tr;
      jac_t j;
      m00 = vx1 - vx0; m01 = vy1 - vy0; m10 = vx2 - vx0; m11 = vy2 - vy0;
      bu0 = vu1 - vu0; bu1 = vu2 - vu0; bv0 = vv1 - vv0; bv1 = vv2 - vv0;
      det = m00 * m11 - m01 * m10;
      j.degen = det == 0;
      j.a = 0; j.b = 0; j.d = 0; j.e = 0;
      if (!j.degen) begin
        j.a = qdiv(m11 * bu0 - m01 * bu1, det);
        j.b = qdiv(m00 * bu1 - m10 * bu0, det);
        j.d = qdiv(m11 * bv0 - m01 * bv1, det);
        j.e = qdiv(m00 * bv1 - m10 * bv0, det);
      end
      j.c = clamp(33'(vu0) - 33'(vx0));
      j.f = clamp(33'(vv0) - 33'(vy0));
      ae = 64'(j.a) * 64'(j.e);
      bd = 64'(j.b) * 64'(j.d);
      tr = 64'(j.a) + 64'(j.e);
      if (ae > bd && tr > 0) j.kind = KIND_DIVERGENT;
      else if (ae > bd && tr < 0) j.kind = KIND_CONVERGENT;
      else j.kind = KIND_STRETCHING;
      pending.push_back(j);
    endfunction

    function void check_result(logic signed [31:0] a, b, d, e, c, f,
                               logic degen, logic [1:0] k);
      jac_t x;
      if (pending.size() == 0) begin
        $error("result word with no triangle outstanding");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (a !== x.a) begin $error("jac_a exp %0d got %0d", x.a, a); errors++; end
      if (b !== x.b) begin $error("jac_b exp %0d got %0d", x.b, b); errors++; end
      if (d !== x.d) begin $error("jac_d exp %0d got %0d", x.d, d); errors++; end
      if (e !== x.e) begin $error("jac_e exp %0d got %0d", x.e, e); errors++; end
      if (c !== x.c) begin $error("offset_c exp %0d got %0d", x.c, c); errors++; end
      if (f !== x.f) begin $error("offset_f exp %0d got %0d", x.f, f); errors++; end
      if (degen !== x.degen) begin
        $error("degenerate exp %0d got %0d", x.degen, degen); errors++;
      end
      if (k !== x.kind) begin $error("kind exp %0d got %0d", x.kind, k); errors++; end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, degenerate;
  logic [1:0] kind;
  logic signed [31:0] x0 = 0, y0 = 0, x1 = 0, y1 = 0, x2 = 0, y2 = 0;
  logic signed [31:0] u0 = 0, v0 = 0, u1 = 0, v1 = 0, u2 = 0, v2 = 0;
  logic signed [31:0] jac_a, jac_b, jac_d, jac_e, offset_c, offset_f;

  jacobian_scoreboard sb = new();
  int send_idle_pct = 20;
  int recv_idle_pct = 68;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  triangle_deformation_tensor #(.FRAC_BITS(FRAC_BITS)) i_dut (.*);

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_triangle(x0, y0, x1, y1, x2, y2, u0, v0, u1, v1, u2, v2);
    if (!rst && out_valid && out_ready)
      sb.check_result(jac_a, jac_b, jac_d, jac_e, offset_c, offset_f, degenerate, kind);
  end

  // receiver: random stalls, or a full hold-off while pressure is applied
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= $urandom_range(99) >= recv_idle_pct;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord(bit bounded);
    case ($urandom_range(5))
      0: return $urandom;
      1: return bounded ? 32'($signed($urandom_range(2000)) - 1000) <<< FRAC_BITS
                        : $urandom;
      2: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
    endcase
  endfunction

  // offer one triangle and hold it until taken
  task automatic send_triangle(logic [31:0] t[12]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {x0, y0, x1, y1, x2, y2} <= {t[0], t[1], t[2], t[3], t[4], t[5]};
    {u0, v0, u1, v1, u2, v2} <= {t[6], t[7], t[8], t[9], t[10], t[11]};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_triangle(bit shared);
    logic [31:0] t[12];
    bit bounded;
    bounded = $urandom_range(3) != 0;
    foreach (t[i]) t[i] = pick_coord(bounded);
    if (shared) begin
      // collinear or repeated vertices give a zero edge determinant
      t[4] = t[2]; t[5] = t[3];
      if ($urandom_range(1)) begin t[2] = t[0]; t[3] = t[1]; end
    end
    send_triangle(t);
  endtask

  task automatic run_phase(int n);
    repeat (n) random_triangle($urandom_range(9) == 0);
  endtask

  initial begin
    logic [31:0] t[12];
    int unsigned w;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // identity, scale, rotation, reflection and contraction on a unit triangle
    for (int k = 0; k < 6; k++) begin
      t = '{0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0};
      case (k)
        0: begin t[8] = 32'h10000; t[11] = 32'h10000; end
        1: begin t[8] = 32'h20000; t[11] = 32'h30000; end
        2: begin t[9] = 32'h10000; t[10] = 32'hffff0000; end
        3: begin t[8] = 32'hffff0000; t[11] = 32'hfffe0000; end
        4: begin t[8] = 32'h10000; t[11] = 32'hffff0000; end
        default: begin t[8] = 32'h8000; t[11] = 32'h8000; t[6] = 32'h1234; end
      endcase
      send_triangle(t);
    end
    // extremes: saturating offsets, huge Jacobians, tiny determinants
    t = '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
          32'h7fffffff, 32'h7fffffff};
    send_triangle(t);
    t = '{0, 0, 1, 0, 0, 1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
          32'h7fffffff, 32'h80000000};
    send_triangle(t);
    t = '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h7fffffff, 1, 2, 3, 4, 5, 6};
    send_triangle(t);
    t = '{0, 0, 3, 0, 0, 3, 0, 0, 1, 0, 0, 1};  // rounding of thirds
    send_triangle(t);
    t = '{0, 0, 2, 0, 0, 2, 0, 0, 1, 0, 0, 32'hffffffff};  // exact halves
    send_triangle(t);
    t = '{5, 5, 5, 5, 5, 5, 7, 7, 1, 1, 2, 2};  // all vertices equal
    send_triangle(t);
    t = '{0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 0, 0, 9, 9, 9, 9};
    send_triangle(t);
    t = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
          32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
          32'hffffffff, 32'hffffffff};
    send_triangle(t);

    run_phase(N_RANDOM / 3);
    send_idle_pct = 68;
    recv_idle_pct = 20;
    run_phase(N_RANDOM / 3);

    // hold the receiver off so the pipeline fills and back-pressures its input
    send_idle_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        w = 0;
        while (w < 200) begin @(posedge clk); w++; end
        hold_off = 1'b0;
      end
      run_phase(80);
    join

    recv_idle_pct = 0;
    run_phase(N_RANDOM / 3);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
